// ===== sv/xcfd_pkg.sv =====
// Shared types and constants for the XOR-checked frame deframer.
package xcfd_pkg;

    // Frame constants
    localparam logic [7:0] XOR_SEED       = 8'h7E;
    localparam logic [7:0] TAIL_MARK      = 8'h81;
    localparam logic [7:0] FRAME_OVERHEAD = 8'd7;
    localparam logic [7:0] PAYLOAD_FIRST  = 8'd4;

    // Queue depth between the classifier and the output stage
    localparam int QUEUE_DEPTH = 2;

    // Field kinds
    localparam logic [2:0] KIND_LENGTH   = 3'd0;
    localparam logic [2:0] KIND_ID       = 3'd1;
    localparam logic [2:0] KIND_ADDRESS  = 3'd2;
    localparam logic [2:0] KIND_FUNCTION = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd4;
    localparam logic [2:0] KIND_CHECKSUM = 3'd5;
    localparam logic [2:0] KIND_TAIL     = 3'd6;
    localparam logic [2:0] KIND_OUTSIDE  = 3'd7;

    // Frame status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_TAIL = 2'd1;
    localparam logic [1:0] STATUS_BAD_CHK  = 2'd2;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd3;

    // Input item
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic [7:0] frame_length;
    } t_dfr_in;

    // Result item
    typedef struct packed {
        logic [2:0] field_kind;
        logic [7:0] field_value;
        logic [7:0] payload_index;
        logic       frame_done;
        logic [1:0] frame_status;
    } t_dfr_out;

    // Classified byte passed from the front to the back
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic [7:0] pidx;
        logic       chk_ok;
        logic       len_bad;
    } t_cls;

endpackage

// ===== sv/xcfd_front.sv =====
// Front end: tracks frame position and XOR, tags each received byte.
module xcfd_front import xcfd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_dfr_in i_data,
    input  logic    i_push_ok,
    output logic    o_push,
    output t_cls    o_cls
);

    logic       r_in_frame, n_in_frame;
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_ptot, n_ptot;
    logic [7:0] r_xor, n_xor;
    logic       r_chk, n_chk;
    logic [7:0] w_pend;
    logic       w_accept;

    assign w_accept = i_valid && i_push_ok;
    assign o_push   = w_accept;
    assign w_pend   = r_ptot + PAYLOAD_FIRST;

    // Classify the byte and work out the next frame state
    always_comb begin
        n_in_frame   = r_in_frame;
        n_pos        = r_pos;
        n_ptot       = r_ptot;
        n_xor        = r_xor;
        n_chk        = r_chk;
        o_cls.kind    = KIND_OUTSIDE;
        o_cls.value   = i_data.rx_byte;
        o_cls.pidx    = 8'd0;
        o_cls.chk_ok  = r_chk;
        o_cls.len_bad = 1'b0;
        if (i_data.frame_start) begin
            o_cls.kind = KIND_LENGTH;
            n_chk      = 1'b0;
            if (i_data.frame_length < FRAME_OVERHEAD) begin
                o_cls.len_bad = 1'b1;
                n_xor         = XOR_SEED;
                n_in_frame    = 1'b0;
                n_pos         = 8'd0;
                n_ptot        = 8'd0;
            end else begin
                n_ptot     = i_data.frame_length - FRAME_OVERHEAD;
                n_xor      = XOR_SEED ^ i_data.rx_byte;
                n_pos      = 8'd1;
                n_in_frame = 1'b1;
            end
        end else if (r_in_frame) begin
            n_pos = r_pos + 8'd1;
            if (r_pos == 8'd1) begin
                o_cls.kind = KIND_ID;
                n_xor      = r_xor ^ i_data.rx_byte;
            end else if (r_pos == 8'd2) begin
                o_cls.kind = KIND_ADDRESS;
                n_xor      = r_xor ^ i_data.rx_byte;
            end else if (r_pos == 8'd3) begin
                o_cls.kind = KIND_FUNCTION;
                n_xor      = r_xor ^ i_data.rx_byte;
            end else if (r_pos >= PAYLOAD_FIRST && r_pos < w_pend) begin
                o_cls.kind = KIND_PAYLOAD;
                o_cls.pidx = r_pos - PAYLOAD_FIRST;
                n_xor      = r_xor ^ i_data.rx_byte;
            end else if (r_pos == w_pend) begin
                o_cls.kind = KIND_CHECKSUM;
                n_chk      = (i_data.rx_byte == ~r_xor);
            end else begin
                o_cls.kind = KIND_TAIL;
                n_in_frame = 1'b0;
                n_pos      = 8'd0;
            end
        end
    end

    // Advance state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= 8'd0;
            r_ptot     <= 8'd0;
            r_xor      <= XOR_SEED;
            r_chk      <= 1'b0;
        end else if (w_accept) begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_ptot     <= n_ptot;
            r_xor      <= n_xor;
            r_chk      <= n_chk;
        end
    end

endmodule

// ===== sv/xcfd_queue.sv =====
// Short queue of classified bytes between front and back.
module xcfd_queue import xcfd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_cls,
    output logic o_not_full,
    input  logic i_pop,
    output logic o_not_empty,
    output t_cls o_cls
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls          r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    assign o_not_full  = (r_count != CW'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_cls       = r_mem[r_rptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cls;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== sv/xcfd_back.sv =====
// Back end: resolves frame status and holds the result register.
module xcfd_back import xcfd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_have,
    input  t_cls     i_cls,
    output logic     o_pop,
    output logic     o_valid,
    input  logic     i_ready,
    output t_dfr_out o_data
);

    logic     r_valid;
    t_dfr_out r_data;
    t_dfr_out n_data;
    logic     w_load;

    assign w_load  = !r_valid || i_ready;
    assign o_pop   = w_load && i_have;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Work out done and status; tail mark is checked before the checksum
    always_comb begin
        n_data.field_kind    = i_cls.kind;
        n_data.field_value   = i_cls.value;
        n_data.payload_index = i_cls.pidx;
        n_data.frame_done    = 1'b0;
        n_data.frame_status  = STATUS_OK;
        if (i_cls.len_bad) begin
            n_data.frame_done   = 1'b1;
            n_data.frame_status = STATUS_BAD_LEN;
        end else if (i_cls.kind == KIND_TAIL) begin
            n_data.frame_done = 1'b1;
            if (i_cls.value != TAIL_MARK) begin
                n_data.frame_status = STATUS_BAD_TAIL;
            end else if (!i_cls.chk_ok) begin
                n_data.frame_status = STATUS_BAD_CHK;
            end
        end
    end

    // Hold the result until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== sv/xor_checked_frame_deframer_top.sv =====
// Top level of the XOR-checked frame deframer.
// An input transfer passes through the queue write and then the result register to the output.
// Throughput: one byte per cycle unless the queue is full; set by the per-byte front update.
// A two-entry queue lets the front keep taking bytes while a result waits.
// Reset (i_rst_n low, synchronous) closes any frame, reseeds the XOR and empties the queue.
module xor_checked_frame_deframer_top import xcfd_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dfr_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_dfr_out o_data
);

    logic w_push;
    logic w_not_full;
    logic w_not_empty;
    logic w_pop;
    t_cls w_front_cls;
    t_cls w_queue_cls;

    assign o_ready = w_not_full;

    xcfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_data    (i_data),
        .i_push_ok (w_not_full),
        .o_push    (w_push),
        .o_cls     (w_front_cls)
    );

    xcfd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_cls       (w_front_cls),
        .o_not_full  (w_not_full),
        .i_pop       (w_pop),
        .o_not_empty (w_not_empty),
        .o_cls       (w_queue_cls)
    );

    xcfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_have  (w_not_empty),
        .i_cls   (w_queue_cls),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

// ===== sv/xcfd_checker.sv =====
// Port-level assertions for the deframer, bound to the top level.
module xcfd_checker import xcfd_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_valid,
    input logic     i_ready,
    input t_dfr_out o_data
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // Status stays ok unless the frame ends
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.frame_done |-> o_data.frame_status == STATUS_OK)
        else $error("status set without frame end");

    // A frame ends only on a tail byte or a bad length byte
    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.frame_done |->
            (o_data.field_kind == KIND_TAIL && o_data.frame_status != STATUS_BAD_LEN) ||
            (o_data.field_kind == KIND_LENGTH && o_data.frame_status == STATUS_BAD_LEN))
        else $error("frame end on wrong field");

    // Payload index is zero outside the payload
    a_pidx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.field_kind != KIND_PAYLOAD |-> o_data.payload_index == 8'd0)
        else $error("payload index outside payload");

    // No result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind xor_checked_frame_deframer_top xcfd_checker u_xcfd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
